// ===== rtl/bpd_pkg.sv =====
// bpd_pkg: shared types and constants of the bmp pixel decoder
// payload structs, configuration set, job format and back-end states
// no dependencies
`timescale 1ns / 1ps
package bpd_pkg;

  localparam logic [2:0] CFG_BPP      = 3'd0;
  localparam logic [2:0] CFG_WIDTH    = 3'd1;
  localparam logic [2:0] CFG_HEIGHT   = 3'd2;
  localparam logic [2:0] CFG_STRIDE   = 3'd3;
  localparam logic [2:0] CFG_BASE     = 3'd4;
  localparam logic [2:0] CFG_RED      = 3'd5;
  localparam logic [2:0] CFG_GREEN    = 3'd6;
  localparam logic [2:0] CFG_BLUE     = 3'd7;

  localparam logic       KIND_DATA    = 1'b0;
  localparam logic       KIND_PALETTE = 1'b1;

  localparam logic [13:0] BYTE_COUNT_MAX = 14'd16383;
  localparam int          DIM_LIMIT      = 4096;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_of_item;
    logic        image_done;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  bits_per_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [14:0] row_stride_bytes;
    logic [31:0] pixel_base;
    logic [31:0] red_coefficients;
    logic [31:0] green_coefficients;
    logic [31:0] blue_coefficients;
  } cfg_t;

  // one unit of work for the back end: a palette write or a run of pixels
  typedef struct packed {
    logic        is_pal;
    logic        direct;
    logic [23:0] rgb;
    logic [7:0]  pal_idx;
    logic [7:0]  data_byte;
    logic [3:0]  bpp;
    logic [3:0]  npix;
    logic [12:0] start_col;
    logic [11:0] row;
    logic        last_row;
    logic [12:0] width;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_SCALE,
    B_MULT,
    B_SUM,
    B_EMIT
  } back_state_t;

endpackage

// ===== rtl/bpd_ram.sv =====
// bpd_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module bpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bpd_job_fifo.sv =====
// bpd_job_fifo: two-entry queue of jobs between front and back end
// depends on bpd_pkg
`timescale 1ns / 1ps
module bpd_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bpd_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output bpd_pkg::job_t rdata,
  output logic          empty
);

  bpd_pkg::job_t mem_r [2];
  logic          wptr_r, wptr_nxt;
  logic          rptr_r, rptr_nxt;
  logic [1:0]    count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r ^ push;
    rptr_nxt  = rptr_r ^ pop;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign rdata = mem_r[rptr_r];

endmodule

// ===== rtl/bpd_front.sv =====
// bpd_front: takes input beats, tracks row/column position and turns palette
// writes and pixel-bearing data bytes into jobs; depends on bpd_pkg
`timescale 1ns / 1ps
module bpd_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  bpd_pkg::in_item_t in_item,
  output logic             in_full,
  input  bpd_pkg::cfg_t    cfg,
  input  logic             job_full,
  output logic             job_push,
  output bpd_pkg::job_t    job
);

  localparam int CAP_INT = (MAX_DIMENSION < bpd_pkg::DIM_LIMIT) ?
                           MAX_DIMENSION : bpd_pkg::DIM_LIMIT;
  localparam logic [12:0] CAP = 13'(CAP_INT);

  logic [13:0] byte_in_row_r, byte_in_row_nxt;
  logic [12:0] column_r, column_nxt;
  logic [12:0] rows_done_r, rows_done_nxt;
  logic [15:0] partial_r, partial_nxt;
  logic [1:0]  phase_r, phase_nxt;

  logic        accept;
  logic [12:0] w, h;
  logic        active, pal_bpp, valid, emit;
  logic [3:0]  count, npix;
  logic [12:0] remaining, col_after;
  logic        row_end;

  assign accept  = in_push && !job_full;
  assign in_full = job_full;

  always_comb begin
    w = (cfg.image_width > CAP) ? CAP : cfg.image_width;
    h = (cfg.image_height > CAP) ? CAP : cfg.image_height;
    active = rows_done_r < h;
    pal_bpp = 1'b1;
    count = 4'd0;
    case (cfg.bits_per_pixel)
      5'd1:    count = 4'd8;
      5'd2:    count = 4'd4;
      5'd4:    count = 4'd2;
      5'd8:    count = 4'd1;
      default: pal_bpp = 1'b0;
    endcase
    valid     = pal_bpp || (cfg.bits_per_pixel == 5'd24);
    remaining = (column_r < w) ? (w - column_r) : 13'd0;
    npix      = 4'd0;
    emit      = 1'b0;
    partial_nxt = partial_r;
    phase_nxt   = phase_r;
    if (pal_bpp) begin
      npix = ({9'd0, count} < remaining) ? count : remaining[3:0];
      emit = npix != 4'd0;
    end else if (valid && column_r < w) begin
      case (phase_r)
        2'd0: begin
          partial_nxt = {8'd0, in_item.data_byte};
          phase_nxt   = 2'd1;
        end
        2'd1: begin
          partial_nxt = {in_item.data_byte, partial_r[7:0]};
          phase_nxt   = 2'd2;
        end
        default: begin
          npix        = 4'd1;
          emit        = 1'b1;
          partial_nxt = 16'd0;
          phase_nxt   = 2'd0;
        end
      endcase
    end
    col_after = column_r + {9'd0, npix};
    row_end   = ({1'b0, byte_in_row_r} + 15'd1 >= cfg.row_stride_bytes) &&
                (!valid || col_after >= w);

    byte_in_row_nxt = byte_in_row_r;
    column_nxt      = col_after;
    rows_done_nxt   = rows_done_r;
    if (row_end) begin
      byte_in_row_nxt = 14'd0;
      column_nxt      = 13'd0;
      rows_done_nxt   = rows_done_r + 13'd1;
      partial_nxt     = 16'd0;
      phase_nxt       = 2'd0;
    end else if (byte_in_row_r < bpd_pkg::BYTE_COUNT_MAX) begin
      byte_in_row_nxt = byte_in_row_r + 14'd1;
    end
  end

  always_comb begin
    job.is_pal    = in_item.kind == bpd_pkg::KIND_PALETTE;
    job.direct    = !pal_bpp;
    job.rgb       = job.is_pal ?
                    {in_item.entry_red, in_item.entry_green, in_item.entry_blue} :
                    {in_item.data_byte, partial_r[15:8], partial_r[7:0]};
    job.pal_idx   = in_item.entry_index;
    job.data_byte = in_item.data_byte;
    job.bpp       = cfg.bits_per_pixel[3:0];
    job.npix      = npix;
    job.start_col = column_r;
    job.row       = 12'(h - 13'd1 - rows_done_r);
    job.last_row  = (rows_done_r + 13'd1) == h;
    job.width     = w;
    job_push = accept && (job.is_pal || (active && emit));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_row_r <= 14'd0;
      column_r      <= 13'd0;
      rows_done_r   <= 13'd0;
      partial_r     <= 16'd0;
      phase_r       <= 2'd0;
    end else if (accept && in_item.kind == bpd_pkg::KIND_DATA && active) begin
      byte_in_row_r <= byte_in_row_nxt;
      column_r      <= column_nxt;
      rows_done_r   <= rows_done_nxt;
      partial_r     <= partial_nxt;
      phase_r       <= phase_nxt;
    end
  end

endmodule

// ===== rtl/bpd_back.sv =====
// bpd_back: runs jobs, palette writes and per-pixel lookup and colour math
// depends on bpd_pkg and bpd_ram
`timescale 1ns / 1ps
module bpd_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_empty,
  input  bpd_pkg::job_t      job,
  output logic               job_pop,
  input  bpd_pkg::cfg_t      cfg,
  input  logic               slot_free,
  output logic               out_we,
  output bpd_pkg::out_item_t out_item
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  bpd_pkg::back_state_t state_r, state_nxt;
  bpd_pkg::job_t        job_r;
  logic [3:0]           k_r;
  logic [12:0]          col_r;
  logic [7:0]           shift_r;
  logic                 oob_r;
  logic [23:0]          prod_r [3];
  logic [31:0]          term_r [3];
  logic [31:0]          sum_r;

  logic [7:0]           idx8;
  logic                 ram_we;
  logic [23:0]          ram_rdata, rgb;
  logic                 more;

  always_comb begin
    case (job_r.bpp)
      4'd1:    idx8 = {7'd0, shift_r[7]};
      4'd2:    idx8 = {6'd0, shift_r[7:6]};
      4'd4:    idx8 = {4'd0, shift_r[7:4]};
      default: idx8 = shift_r;
    endcase
  end

  assign more = (k_r + 4'd1) < job_r.npix;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpd_pkg::B_IDLE: begin
        if (!job_empty && !job.is_pal) begin
          state_nxt = job.direct ? bpd_pkg::B_SCALE : bpd_pkg::B_READ;
        end
      end
      bpd_pkg::B_READ:  state_nxt = bpd_pkg::B_SCALE;
      bpd_pkg::B_SCALE: state_nxt = bpd_pkg::B_MULT;
      bpd_pkg::B_MULT:  state_nxt = bpd_pkg::B_SUM;
      bpd_pkg::B_SUM:   state_nxt = bpd_pkg::B_EMIT;
      bpd_pkg::B_EMIT: begin
        if (slot_free) begin
          state_nxt = more ? bpd_pkg::B_READ : bpd_pkg::B_IDLE;
        end
      end
      default: state_nxt = bpd_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    job_pop = (state_r == bpd_pkg::B_IDLE) && !job_empty;
    ram_we  = job_pop && job.is_pal && ({1'b0, job.pal_idx} < DEPTH9);
    out_we  = (state_r == bpd_pkg::B_EMIT) && slot_free;
  end

  bpd_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (job.pal_idx[AW-1:0]),
    .wdata (job.rgb),
    .raddr (idx8[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rgb = job_r.direct ? job_r.rgb : (oob_r ? 24'd0 : ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpd_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      bpd_pkg::B_IDLE: begin
        if (job_pop) begin
          job_r   <= job;
          k_r     <= 4'd0;
          col_r   <= job.start_col;
          shift_r <= job.data_byte;
        end
      end
      bpd_pkg::B_READ: oob_r <= {1'b0, idx8} >= DEPTH9;
      bpd_pkg::B_SCALE: begin
        prod_r[0] <= rgb[23:16] * cfg.red_coefficients[15:0];
        prod_r[1] <= rgb[15:8] * cfg.green_coefficients[15:0];
        prod_r[2] <= rgb[7:0] * cfg.blue_coefficients[15:0];
      end
      bpd_pkg::B_MULT: begin
        term_r[0] <= prod_r[0][23:8] * cfg.red_coefficients[31:16];
        term_r[1] <= prod_r[1][23:8] * cfg.green_coefficients[31:16];
        term_r[2] <= prod_r[2][23:8] * cfg.blue_coefficients[31:16];
      end
      bpd_pkg::B_SUM: sum_r <= cfg.pixel_base + term_r[0] + term_r[1] + term_r[2];
      bpd_pkg::B_EMIT: begin
        if (out_we) begin
          k_r     <= k_r + 4'd1;
          col_r   <= col_r + 13'd1;
          shift_r <= shift_r << job_r.bpp;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_item.pixel_value  = sum_r;
    out_item.column       = col_r[11:0];
    out_item.row          = job_r.row;
    out_item.last_of_item = !more;
    out_item.image_done   = job_r.last_row && ((col_r + 13'd1) == job_r.width);
  end

endmodule

// ===== rtl/bmp_pixel_decoder.sv =====
// bmp_pixel_decoder: top level, configuration registers and result register
// depends on bpd_pkg, bpd_front, bpd_job_fifo, bpd_back
//
// Usage: pixel-area bytes (kind 0) and palette writes (kind 1) enter as beats
// on the in_ queue port (push/full). Each data byte gives 0 to 8 pixels on
// the out_ queue port (empty/pop), each with column, row, a last-of-byte flag
// and an image-done flag on the final pixel. Palette writes give nothing.
// Registers are written on the cfg_ port (valid/ready, ready always high);
// the user must write them only while the block is idle; the block does not enforce it.
// Timing: the front end takes a beat per cycle, while the two-entry job queue
// is not full. The back end takes a job in its idle step, then runs each
// palette-indexed pixel through ram read, scale, multiply, sum and emit, and
// each 24-bit pixel through the same steps without the ram read; palette
// writes are done in the idle step. It takes no new job until the last is
// emitted, and the emit step waits while the result register is held.
// Reset (synchronous, rst_n low) restores register defaults and clears the
// position counters and queues; palette contents stay undefined until written.
// When pop is held low, the result register holds, the back end waits in
// its emit step, the job queue fills and full rises.
`timescale 1ns / 1ps
module bmp_pixel_decoder #(
  parameter int MAX_DIMENSION = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  bpd_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output bpd_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  bpd_pkg::cfg_t      cfg_r;
  bpd_pkg::job_t      job_in, job_out;
  logic               job_push, job_pop, job_full, job_empty;
  logic               out_valid_r, out_valid_nxt;
  bpd_pkg::out_item_t out_r, back_item;
  logic               back_we, slot_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bits_per_pixel     <= 5'd8;
      cfg_r.image_width        <= 13'd1;
      cfg_r.image_height       <= 13'd1;
      cfg_r.row_stride_bytes   <= 15'd4;
      cfg_r.pixel_base         <= 32'd0;
      cfg_r.red_coefficients   <= 32'd0;
      cfg_r.green_coefficients <= 32'd0;
      cfg_r.blue_coefficients  <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpd_pkg::CFG_BPP:    cfg_r.bits_per_pixel     <= cfg_data[4:0];
        bpd_pkg::CFG_WIDTH:  cfg_r.image_width        <= cfg_data[12:0];
        bpd_pkg::CFG_HEIGHT: cfg_r.image_height       <= cfg_data[12:0];
        bpd_pkg::CFG_STRIDE: cfg_r.row_stride_bytes   <= cfg_data[14:0];
        bpd_pkg::CFG_BASE:   cfg_r.pixel_base         <= cfg_data;
        bpd_pkg::CFG_RED:    cfg_r.red_coefficients   <= cfg_data;
        bpd_pkg::CFG_GREEN:  cfg_r.green_coefficients <= cfg_data;
        bpd_pkg::CFG_BLUE:   cfg_r.blue_coefficients  <= cfg_data;
        default: ;
      endcase
    end
  end

  bpd_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cfg      (cfg_r),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  bpd_job_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  bpd_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .cfg       (cfg_r),
    .slot_free (slot_free),
    .out_we    (back_we),
    .out_item  (back_item)
  );

  // result register: one beat held until popped
  assign slot_free = !out_valid_r || out_pop;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (back_we) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (back_we) begin
      out_r <= back_item;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && job_full))
    else $error("job pushed into full queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    back_we |-> (!out_valid_r || out_pop))
    else $error("result register overwritten before pop");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present right after reset");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("job popped from empty queue");

endmodule
